/* rtl/core/uxf_pkg.sv */
// Shared types and constants for the serial buffering engine with XON/XOFF flow control.
`timescale 1ns / 1ps
`default_nettype none

package uxf_pkg;

    localparam int DEPTH_DEFAULT = 512;

    localparam logic [7:0] CHAR_XON  = 8'd17;
    localparam logic [7:0] CHAR_XOFF = 8'd19;
    localparam logic [7:0] NO_BYTE   = 8'hFF;

    localparam logic       FLOW_ENABLE_RESET = 1'b1;
    localparam logic [8:0] XOFF_LEVEL_RESET  = 9'd384;
    localparam logic [8:0] XON_LEVEL_RESET   = 9'd256;

    localparam int ADDR_WIDTH = 4;

    typedef enum logic [1:0] {
        ACT_RX_BYTE  = 2'd0,
        ACT_PUT      = 2'd1,
        ACT_GET      = 2'd2,
        ACT_TX_READY = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_FLOW_ENABLE = 2'd0,
        REG_XOFF_LEVEL  = 2'd1,
        REG_XON_LEVEL   = 2'd2,
        REG_NONE        = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        SRC_RESULT = 2'd0,
        SRC_RX_RAM = 2'd1,
        SRC_TX_RAM = 2'd2,
        SRC_NONE   = 2'd3
    } data_src_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_out;
        logic [8:0] fill_count;
        logic       line_byte_valid;
        logic       transmit_enabled;
        logic       flow_stopped;
    } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/uxf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module uxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = uxf_pkg::DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/uart_fifo_xon_xoff_flow_control.sv */
// Top level of the serial buffering engine: receive and transmit rings with XON/XOFF control.
// Each request item carries one event: a byte received from the line, a software put, a
// software get, or the transmitter asking for its next byte. Every item gives exactly one
// response item on the rsp channel; both channels use valid and ready.
// An item accepted at one clock edge has its response valid after that edge, and one item can
// be accepted in every cycle while the response is not stalled. The rate is set by the single
// read or write port of each ring RAM, which every item uses at most once.
// Ring bytes read by a get or sent to the line leave the RAM's read register directly.
// A stalled response holds, and no new item is accepted until it is taken; the request
// ready follows the response register being empty or being taken in the same cycle.
// Reset clears the ring indices, response valid and flow flags but sets resume_sent; ring
// contents are not cleared and need not be, as an entry is only read after it was written.
// The APB port holds flow_enable at 0x0, xoff_level at 0x4 and xon_level at 0x8; writes
// must be made by the user only while no item is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module uart_fifo_xon_xoff_flow_control #(
    parameter int DEPTH = uxf_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire uxf_pkg::req_t                   req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output uxf_pkg::rsp_t                        rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [uxf_pkg::ADDR_WIDTH-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW > 9) ? AW : 9;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] i);
        logic [AW:0] inc;
        inc = {1'b0, i} + (AW + 1)'(1);
        return (inc >= DEPTH_W) ? '0 : inc[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] level(input logic [AW-1:0] wr, input logic [AW-1:0] rd);
        logic [AW:0] diff;
        if (wr >= rd)
        begin
            diff = {1'b0, wr} - {1'b0, rd};
        end
        else
        begin
            diff = DEPTH_W - {1'b0, rd} + {1'b0, wr};
        end
        return diff[AW-1:0];
    endfunction

    // Configuration registers
    logic       flow_enable_reg;
    logic [8:0] xoff_level_reg;
    logic [8:0] xon_level_reg;
    logic       cfg_write;
    logic [1:0] cfg_index;

    // Engine state
    logic [AW-1:0] rx_wr_reg, rx_wr_next;
    logic [AW-1:0] rx_rd_reg, rx_rd_next;
    logic [AW-1:0] tx_wr_reg, tx_wr_next;
    logic [AW-1:0] tx_rd_reg, tx_rd_next;
    logic          stop_sent_reg, stop_sent_next;
    logic          resume_sent_reg, resume_sent_next;
    logic          pending_reg, pending_next;
    logic          treq_reg, treq_next;

    // Response register
    logic          rsp_valid_reg, rsp_valid_next;
    uxf_pkg::rsp_t rsp_reg, rsp_next;
    logic [1:0]    src_reg, src_next;

    logic          accept;
    logic [AW-1:0] rx_wr_adv, tx_wr_adv, rx_rd_adv, tx_rd_adv;
    logic          rx_full, tx_full, rx_empty, tx_empty;
    logic [CW-1:0] rx_fill, tx_fill;
    logic          rx_we, rx_re, tx_we, tx_re;
    logic [7:0]    rx_rdata, tx_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_enable_reg <= uxf_pkg::FLOW_ENABLE_RESET;
            xoff_level_reg  <= uxf_pkg::XOFF_LEVEL_RESET;
            xon_level_reg   <= uxf_pkg::XON_LEVEL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                uxf_pkg::REG_FLOW_ENABLE: flow_enable_reg <= pwdata[0];
                uxf_pkg::REG_XOFF_LEVEL:  xoff_level_reg  <= pwdata[8:0];
                uxf_pkg::REG_XON_LEVEL:   xon_level_reg   <= pwdata[8:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            uxf_pkg::REG_FLOW_ENABLE: prdata = {31'd0, flow_enable_reg};
            uxf_pkg::REG_XOFF_LEVEL:  prdata = {23'd0, xoff_level_reg};
            uxf_pkg::REG_XON_LEVEL:   prdata = {23'd0, xon_level_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    assign rx_wr_adv = advance(rx_wr_reg);
    assign tx_wr_adv = advance(tx_wr_reg);
    assign rx_rd_adv = advance(rx_rd_reg);
    assign tx_rd_adv = advance(tx_rd_reg);
    assign rx_full   = (rx_wr_adv == rx_rd_reg);
    assign tx_full   = (tx_wr_adv == tx_rd_reg);
    assign rx_empty  = (rx_rd_reg == rx_wr_reg);
    assign tx_empty  = (tx_rd_reg == tx_wr_reg);
    assign rx_fill   = CW'(level(rx_wr_adv, rx_rd_reg));
    assign tx_fill   = CW'(level(tx_wr_adv, tx_rd_reg));

    always_comb
    begin
        rx_wr_next       = rx_wr_reg;
        rx_rd_next       = rx_rd_reg;
        tx_wr_next       = tx_wr_reg;
        tx_rd_next       = tx_rd_reg;
        stop_sent_next   = stop_sent_reg;
        resume_sent_next = resume_sent_reg;
        pending_next     = pending_reg;
        treq_next        = treq_reg;
        rx_we            = 1'b0;
        rx_re            = 1'b0;
        tx_we            = 1'b0;
        tx_re            = 1'b0;
        src_next         = uxf_pkg::SRC_RESULT;
        rsp_next         = '0;

        unique case (uxf_pkg::action_t'(req.action))
            uxf_pkg::ACT_RX_BYTE:
            begin
                if (rx_full)
                begin
                    rsp_next.status = uxf_pkg::ST_FULL;
                end
                else
                begin
                    rx_we                = 1'b1;
                    rx_wr_next           = rx_wr_adv;
                    rsp_next.fill_count  = rx_fill[8:0];
                    if (flow_enable_reg)
                    begin
                        if (rx_fill >= CW'(xoff_level_reg))
                        begin
                            resume_sent_next = 1'b0;
                            if (!stop_sent_reg)
                            begin
                                stop_sent_next = 1'b1;
                                pending_next   = 1'b1;
                                treq_next      = 1'b1;
                            end
                        end
                        else if (rx_fill <= CW'(xon_level_reg))
                        begin
                            stop_sent_next = 1'b0;
                            if (!resume_sent_reg)
                            begin
                                resume_sent_next = 1'b1;
                                pending_next     = 1'b1;
                                treq_next        = 1'b1;
                            end
                        end
                    end
                end
            end
            uxf_pkg::ACT_PUT:
            begin
                if (tx_full)
                begin
                    rsp_next.status = uxf_pkg::ST_FULL;
                end
                else
                begin
                    tx_we               = 1'b1;
                    tx_wr_next          = tx_wr_adv;
                    rsp_next.fill_count = tx_fill[8:0];
                    if (tx_fill == CW'(1))
                    begin
                        treq_next = 1'b1;
                    end
                end
            end
            uxf_pkg::ACT_GET:
            begin
                if (rx_empty)
                begin
                    rsp_next.status   = uxf_pkg::ST_EMPTY;
                    rsp_next.data_out = uxf_pkg::NO_BYTE;
                end
                else
                begin
                    rx_re      = 1'b1;
                    rx_rd_next = rx_rd_adv;
                    src_next   = uxf_pkg::SRC_RX_RAM;
                end
            end
            uxf_pkg::ACT_TX_READY:
            begin
                if (!treq_reg)
                begin
                    rsp_next.status   = uxf_pkg::ST_EMPTY;
                    rsp_next.data_out = uxf_pkg::NO_BYTE;
                end
                else if (pending_reg)
                begin
                    pending_next             = 1'b0;
                    rsp_next.line_byte_valid = 1'b1;
                    if (resume_sent_reg)
                    begin
                        rsp_next.data_out = uxf_pkg::CHAR_XON;
                    end
                    else if (stop_sent_reg)
                    begin
                        rsp_next.data_out = uxf_pkg::CHAR_XOFF;
                    end
                end
                else if (!tx_empty)
                begin
                    tx_re                    = 1'b1;
                    tx_rd_next               = tx_rd_adv;
                    src_next                 = uxf_pkg::SRC_TX_RAM;
                    rsp_next.line_byte_valid = 1'b1;
                end
                else
                begin
                    treq_next         = 1'b0;
                    rsp_next.status   = uxf_pkg::ST_EMPTY;
                    rsp_next.data_out = uxf_pkg::NO_BYTE;
                end
            end
            default:
            begin
            end
        endcase

        rsp_next.transmit_enabled = treq_next;
        rsp_next.flow_stopped     = stop_sent_next;
        rsp_valid_next            = accept || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_reg       <= '0;
            rx_rd_reg       <= '0;
            tx_wr_reg       <= '0;
            tx_rd_reg       <= '0;
            stop_sent_reg   <= 1'b0;
            resume_sent_reg <= 1'b1;
            pending_reg     <= 1'b0;
            treq_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                rx_wr_reg       <= rx_wr_next;
                rx_rd_reg       <= rx_rd_next;
                tx_wr_reg       <= tx_wr_next;
                tx_rd_reg       <= tx_rd_next;
                stop_sent_reg   <= stop_sent_next;
                resume_sent_reg <= resume_sent_next;
                pending_reg     <= pending_next;
                treq_reg        <= treq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
            src_reg <= src_next;
        end
    end

    uxf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (accept && rx_we),
        .waddr (rx_wr_reg),
        .wdata (req.data_byte),
        .re    (accept && rx_re),
        .raddr (rx_rd_reg),
        .rdata (rx_rdata)
    );

    uxf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (accept && tx_we),
        .waddr (tx_wr_reg),
        .wdata (req.data_byte),
        .re    (accept && tx_re),
        .raddr (tx_rd_reg),
        .rdata (tx_rdata)
    );

    always_comb
    begin
        rsp = rsp_reg;
        unique case (uxf_pkg::data_src_t'(src_reg))
            uxf_pkg::SRC_RX_RAM: rsp.data_out = rx_rdata;
            uxf_pkg::SRC_TX_RAM: rsp.data_out = tx_rdata;
            default:             rsp.data_out = rsp_reg.data_out;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire
